FILE: hw/rtl/gsp_pkg.sv
package gsp_pkg;

   // Store geometry.
   localparam int CAPACITY   = 64;
   localparam int GROUP_SIZE = 5;

   // Field widths of the item and result channels.
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int GROUP_W  = 4;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W  = 7;

   // Derived widths: fill count, memory address and the compare width for group bases.
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int BASE_W = GROUP_W + $clog2(GROUP_SIZE + 1);
   localparam int CMP_W  = ((FILL_W > BASE_W) ? FILL_W : BASE_W) + 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_POP_AT = 2'd2,
      FUNC_NOP    = 2'd3
   } gsp_func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_BAD_GROUP = 2'd3
   } gsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_WAIT,
      ST_SHIFT,
      ST_TOP_RD,
      ST_FINISH
   } gsp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic decode;
      logic pop_capture;
      logic shift_step;
      logic top_read;
      logic out_load;
   } gsp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      gsp_func_type func;
      logic         empty;
      logic         bad_group;
      logic         shift_done;
      logic         out_free;
   } gsp_stat_type;

endpackage

FILE: hw/rtl/gsp_if.sv
interface gsp_req_if;
   import gsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic signed [DATA_W-1:0]   value;
   logic [GROUP_W-1:0]         group_index;

   modport source (output valid, output func, output value, output group_index, input ready);
   modport sink   (input valid, input func, input value, input group_index, output ready);
endinterface

interface gsp_rsp_if;
   import gsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   popped_value;
   logic [STATUS_W-1:0]        status;
   logic signed [DATA_W-1:0]   top_value;
   logic [LEVEL_W-1:0]         level;

   modport source (output valid, output popped_value, output status, output top_value,
                   output level, input ready);
   modport sink   (input valid, input popped_value, input status, input top_value,
                   input level, output ready);
endinterface

FILE: hw/rtl/gsp_ctrl.sv
module gsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gsp_pkg::gsp_stat_type stat,
   output gsp_pkg::gsp_cmd_type  cmd
);
   import gsp_pkg::*;

   gsp_state_type state_ff;
   gsp_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.func)
               FUNC_POP:    state_in = stat.empty ? ST_TOP_RD : ST_POP_WAIT;
               FUNC_POP_AT: state_in = stat.bad_group ? ST_TOP_RD : ST_POP_WAIT;
               default:     state_in = ST_TOP_RD;
            endcase
         end
         ST_POP_WAIT: begin
            state_in = (stat.func == FUNC_POP_AT) ? ST_SHIFT : ST_TOP_RD;
         end
         ST_SHIFT: begin
            if (stat.shift_done) state_in = ST_TOP_RD;
         end
         ST_TOP_RD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_DECODE:   cmd.decode      = 1'b1;
         ST_POP_WAIT: cmd.pop_capture = 1'b1;
         ST_SHIFT:    cmd.shift_step  = 1'b1;
         ST_TOP_RD:   cmd.top_read    = 1'b1;
         ST_FINISH:   cmd.out_load    = stat.out_free;
         default: begin
         end
      endcase
   end

endmodule

FILE: hw/rtl/gsp_datapath.sv
module gsp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gsp_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [gsp_pkg::DATA_W-1:0]   req_value,
   input  logic [gsp_pkg::GROUP_W-1:0]         req_group_index,
   input  gsp_pkg::gsp_cmd_type                cmd,
   output gsp_pkg::gsp_stat_type               stat,
   gsp_rsp_if.source                           rsp
);
   import gsp_pkg::*;

   // Stack memory and its registered read data.
   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // Item registers.
   gsp_func_type       func_ff;
   logic [DATA_W-1:0]  value_ff;
   logic [GROUP_W-1:0] group_ff;
   logic [DATA_W-1:0]  popped_ff;
   gsp_status_type     status_ff;

   // Control state.
   logic [FILL_W-1:0] fill_ff,   fill_in;
   logic [FILL_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] wr_addr_ff, wr_addr_in;
   logic              pend_ff,   pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Output register payload.
   logic [DATA_W-1:0]   out_popped_ff;
   gsp_status_type      out_status_ff;
   logic [DATA_W-1:0]   out_top_ff;
   logic [LEVEL_W-1:0]  out_level_ff;

   // Decode helpers.
   logic [CMP_W-1:0]  fill_ext, base_ext, pos_raw, last_ext, pos_ext;
   logic [FILL_W-1:0] pos, fill_m1;
   logic              full, empty, bad_group, rd_avail, shift_done;

   // Memory port controls.
   logic              rd_en, wr_en;
   logic [FILL_W-1:0] rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data;

   // Position of a pop-at: the top of the group, or the overall top if lower.
   always_comb begin
      fill_ext  = CMP_W'(fill_ff);
      base_ext  = CMP_W'(group_ff) * CMP_W'(GROUP_SIZE);
      pos_raw   = base_ext + CMP_W'(GROUP_SIZE - 1);
      last_ext  = fill_ext - CMP_W'(1);
      pos_ext   = (pos_raw > last_ext) ? last_ext : pos_raw;
      pos       = pos_ext[FILL_W-1:0];
      fill_m1   = fill_ff - FILL_W'(1);
      full      = (fill_ff == FILL_W'(CAPACITY));
      empty     = (fill_ff == '0);
      bad_group = (base_ext >= fill_ext);
      rd_avail  = (rd_ptr_ff < fill_ff);
      shift_done = !rd_avail && !pend_ff;
   end

   assign stat.func       = func_ff;
   assign stat.empty      = empty;
   assign stat.bad_group  = bad_group;
   assign stat.shift_done = shift_done;
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

   // Memory port selection. The shift reads one entry ahead and writes it back one below.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = fill_m1;
      wr_en   = 1'b0;
      wr_addr = fill_ff;
      wr_data = value_ff;
      if (cmd.decode && func_ff == FUNC_PUSH && !full) begin
         wr_en = 1'b1;
      end
      if (cmd.decode && func_ff == FUNC_POP && !empty) begin
         rd_en = 1'b1;
      end
      if (cmd.decode && func_ff == FUNC_POP_AT && !bad_group) begin
         rd_en   = 1'b1;
         rd_addr = pos;
      end
      if (cmd.shift_step && rd_avail) begin
         rd_en   = 1'b1;
         rd_addr = rd_ptr_ff;
      end
      if (cmd.shift_step && pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = wr_addr_ff;
         wr_data = rd_data_ff;
      end
      if (cmd.top_read && !empty) begin
         rd_en = 1'b1;
      end
   end

   // Memory.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[ADDR_W-1:0]] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
   end

   // Next values of the control state.
   always_comb begin
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_addr_in   = wr_addr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.decode && func_ff == FUNC_PUSH && !full) fill_in = fill_ff + FILL_W'(1);
      if (cmd.pop_capture) begin
         if (func_ff == FUNC_POP) fill_in = fill_m1;
         rd_ptr_in = pos + FILL_W'(1);
         pend_in   = 1'b0;
      end
      if (cmd.shift_step) begin
         pend_in = rd_avail;
         if (rd_avail) begin
            rd_ptr_in  = rd_ptr_ff + FILL_W'(1);
            wr_addr_in = rd_ptr_ff - FILL_W'(1);
         end
         if (shift_done) fill_in = fill_m1;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_addr_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_addr_ff   <= wr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item registers: fields at acceptance, status at decode, removed value after its read.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= gsp_func_type'(req_func);
         value_ff  <= req_value;
         group_ff  <= req_group_index;
         popped_ff <= '0;
      end
      if (cmd.decode) begin
         if (func_ff == FUNC_PUSH && full) begin
            status_ff <= STAT_FULL;
         end else if (func_ff == FUNC_POP && empty) begin
            status_ff <= STAT_EMPTY;
         end else if (func_ff == FUNC_POP_AT && bad_group) begin
            status_ff <= STAT_BAD_GROUP;
         end else begin
            status_ff <= STAT_OK;
         end
      end
      if (cmd.pop_capture) popped_ff <= rd_data_ff;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_popped_ff <= popped_ff;
         out_status_ff <= status_ff;
         out_top_ff    <= empty ? '0 : rd_data_ff;
         out_level_ff  <= LEVEL_W'(fill_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.popped_value = out_popped_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.top_value    = out_top_ff;
   assign rsp.level        = out_level_ff;

   // The fill count never passes the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count above capacity");

   // A pending shift write always lands below the entry being read.
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (wr_addr_ff < rd_ptr_ff) && (rd_ptr_ff <= fill_ff))
      else $error("shift write address out of order");

   // A full report is only given with the stack at capacity.
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && status_ff == STAT_FULL) |-> fill_ff == FILL_W'(CAPACITY))
      else $error("full status with free space");

   // The result register comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

FILE: hw/rtl/grouped_stack_with_pop_at_top.sv
// Channel   Direction  Fields
// req_if    in         func, value, group_index
// rsp_if    out        popped_value, status, top_value, level
//
// An item is taken only while the controller is idle. After acceptance the controller steps
// through decode, top read and finish for a push, a no-op or a rejected pop or pop-at; a pop
// adds a capture state before the top read, and a pop-at adds the capture and a shift loop
// moving each entry above the removed one down, one per cycle through the single ports.
// Reset is synchronous and empties the stack; stored words are not cleared.
// A stalled result holds in the output register and the next item waits for it.
module grouped_stack_with_pop_at_top (
   input  logic      clock,
   input  logic      reset,
   gsp_req_if.sink   req_if,
   gsp_rsp_if.source rsp_if
);
   import gsp_pkg::*;

   gsp_cmd_type  cmd;
   gsp_stat_type stat;
   logic         ready;

   // Sequencer.
   gsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_if.ready = ready;

   // Store, pointers and result register.
   gsp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_if.func),
      .req_value       (req_if.value),
      .req_group_index (req_if.group_index),
      .cmd             (cmd),
      .stat            (stat),
      .rsp             (rsp_if)
   );

endmodule
